### design/contact_range_bearing_rate_macros.svh
// Assertion macros for contact_range_bearing_rate
`ifndef CONTACT_RANGE_BEARING_RATE_MACROS_SVH
`define CONTACT_RANGE_BEARING_RATE_MACROS_SVH

`ifndef SYNTH
`define CRBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crbr assertion failed");
`define CRBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crbr assertion failed");
`else
`define CRBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CRBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### design/crbr_pkg.sv
package crbr_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int VEC_LAT      = CORDIC_STEPS + 1;
  localparam int ROT_LAT      = CORDIC_STEPS + 2;

  localparam logic [31:0] MAX_RANGE_RST  = 32'd355584;
  localparam logic [16:0] KN_PER_MPS_Q16 = 17'd127392;
  localparam logic        REG_MAX_RANGE  = 1'b0;

  typedef logic signed [32:0] diff_t;

  typedef struct packed {
    logic [15:0] hdg;
    logic [15:0] cog;
    logic [15:0] sog;
    logic [16:0] own_kn;
    logic        zero;
  } side_t;

  function automatic logic [31:0] atan_entry(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### design/crbr_isqrt.sv
module crbr_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] rad_i,
  output logic        valid_o,
  output logic [31:0] root_o
);
  import crbr_pkg::*;

  logic [63:0] rad_q  [SQRT_STEPS];
  logic [33:0] rem_q  [SQRT_STEPS];
  logic [31:0] root_q [SQRT_STEPS];
  logic        v_q    [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [63:0] p_rad;
    logic [33:0] p_rem;
    logic [31:0] p_root;
    logic        p_v;
    logic [34:0] rem_t;
    logic [34:0] trial;

    if (k == 0) begin : g_first
      assign p_rad  = rad_i;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_v    = valid_i;
    end else begin : g_next
      assign p_rad  = rad_q[k-1];
      assign p_rem  = rem_q[k-1];
      assign p_root = root_q[k-1];
      assign p_v    = v_q[k-1];
    end

    assign rem_t = {p_rem[32:0], p_rad[63:62]};
    assign trial = {1'b0, p_root, 2'b01};

    always_ff @(posedge clk_i) begin
      rad_q[k] <= {p_rad[61:0], 2'b00};
      if (rem_t >= trial) begin
        rem_q[k]  <= 34'(rem_t - trial);
        root_q[k] <= {p_root[30:0], 1'b1};
      end else begin
        rem_q[k]  <= 34'(rem_t);
        root_q[k] <= {p_root[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= p_v;
      end
    end
  end

  assign root_o  = root_q[SQRT_STEPS-1];
  assign valid_o = v_q[SQRT_STEPS-1];

endmodule

### design/crbr_vec.sv
module crbr_vec (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  crbr_pkg::diff_t      e_i,
  input  crbr_pkg::diff_t      n_i,
  output logic                 valid_o,
  output logic [31:0]          theta_o
);
  import crbr_pkg::*;

  localparam int XW = 36;

  logic signed [XW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_q [CORDIC_STEPS+1];
  logic [31:0]          z_q [CORDIC_STEPS+1];
  logic                 v_q [CORDIC_STEPS+1];

  // fold left half-plane onto the right
  always_ff @(posedge clk_i) begin
    if (n_i < 0) begin
      x_q[0] <= -XW'(n_i);
      y_q[0] <= -XW'(e_i);
      z_q[0] <= 32'h8000_0000;
    end else begin
      x_q[0] <= XW'(n_i);
      y_q[0] <= XW'(e_i);
      z_q[0] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (y_q[k] > 0) begin
        x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] + atan_entry(k);
      end else begin
        x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] - atan_entry(k);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end
  end

  assign theta_o = z_q[CORDIC_STEPS];
  assign valid_o = v_q[CORDIC_STEPS];

endmodule

### design/crbr_rot.sv
module crbr_rot (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [31:0]        ang_i,
  output logic               valid_o,
  output logic signed [31:0] cos_o
);
  import crbr_pkg::*;

  localparam int SW = 34;
  localparam logic signed [SW-1:0] QTR  = 34'sh0_4000_0000;
  localparam logic signed [SW-1:0] HALF = 34'sh0_8000_0000;
  localparam logic signed [SW-1:0] KQ30 = 34'sd652032874;

  logic signed [SW-1:0] s_q   [CORDIC_STEPS+1];
  logic signed [SW-1:0] x_q   [CORDIC_STEPS+1];
  logic signed [SW-1:0] y_q   [CORDIC_STEPS+1];
  logic                 neg_q [CORDIC_STEPS+1];
  logic                 v_q   [CORDIC_STEPS+1];
  logic signed [31:0]   cos_q;
  logic                 vout_q;
  logic signed [SW-1:0] s_in;
  logic signed [SW-1:0] s_adj;
  logic                 neg_in;

  always_comb begin
    s_in   = SW'(signed'(ang_i));
    s_adj  = s_in;
    neg_in = 1'b0;
    if (s_in > QTR) begin
      s_adj  = s_in - HALF;
      neg_in = 1'b1;
    end else if (s_in < -QTR) begin
      s_adj  = s_in + HALF;
      neg_in = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q[0]   <= s_adj;
    x_q[0]   <= KQ30;
    y_q[0]   <= '0;
    neg_q[0] <= neg_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    always_ff @(posedge clk_i) begin
      neg_q[k+1] <= neg_q[k];
      if (s_q[k] >= 0) begin
        x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
        s_q[k+1] <= s_q[k] - SW'(atan_entry(k));
      end else begin
        x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
        s_q[k+1] <= s_q[k] + SW'(atan_entry(k));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (neg_q[CORDIC_STEPS]) begin
      cos_q <= 32'(-x_q[CORDIC_STEPS]);
    end else begin
      cos_q <= 32'(x_q[CORDIC_STEPS]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else begin
      vout_q <= v_q[CORDIC_STEPS];
    end
  end

  assign cos_o   = cos_q;
  assign valid_o = vout_q;

endmodule

### design/contact_range_bearing_rate.sv
// Range, bearing and range rate to one contact per request. A request is taken on
// every cycle that start is high (busy never rises) and its result appears on the
// result ports, marked by done_o, for one cycle; results come out in request order
// at one per cycle. The receiver cannot stall, so it must take each result in the
// cycle it is shown. Latency is set by the 30-step vectoring CORDIC for the bearing
// followed by the 30-step rotation CORDICs for the two cosines; the 32-step square
// root for the range runs alongside.
`include "contact_range_bearing_rate_macros.svh"

module contact_range_bearing_rate (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] own_east_i,
  input  logic signed [31:0] own_north_i,
  input  logic [15:0]        own_heading_i,
  input  logic [15:0]        own_speed_i,
  input  logic signed [31:0] tgt_east_i,
  input  logic signed [31:0] tgt_north_i,
  input  logic [15:0]        tgt_course_i,
  input  logic [15:0]        tgt_speed_kn_i,
  output logic               done_o,
  output logic [31:0]        target_range_o,
  output logic [15:0]        true_bearing_o,
  output logic signed [15:0] rel_bearing_o,
  output logic signed [18:0] radial_speed_o,
  output logic               is_closing_o,
  output logic               in_range_o
);
  import crbr_pkg::*;

  localparam int T_THETA = VEC_LAT;
  localparam int T_ANG   = T_THETA + 1;
  localparam int T_COS   = T_ANG + ROT_LAT;
  localparam int T_MUL   = T_COS + 1;
  localparam int T_OUT   = T_MUL + 1;
  localparam int T_RNG   = 2 + SQRT_STEPS;
  localparam int TB_N    = T_MUL - T_ANG + 1;
  localparam int RNG_N   = T_MUL - T_RNG;

  localparam logic signed [51:0] ROUND_HALF = 52'sd536870912;
  localparam logic signed [21:0] RAD_MAX    = 22'sd262143;
  localparam logic signed [21:0] RAD_MIN    = -22'sd262144;

  // configuration
  logic [31:0] max_range_q;
  logic        reg_idx;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_MAX_RANGE) ? max_range_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_range_q <= MAX_RANGE_RST;
    end else if (psel && penable && pwrite && (reg_idx == REG_MAX_RANGE)) begin
      max_range_q <= pwdata;
    end
  end

  // request stage
  logic        accept;
  logic [33:0] kn_prod;
  side_t       side_in;
  diff_t       de_q;
  diff_t       dn_q;
  logic        valid_q [T_MUL+1];
  side_t       side_q  [T_MUL+1];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign kn_prod = 34'(own_speed_i) * 34'(KN_PER_MPS_Q16) + 34'd32768;

  always_comb begin
    side_in.hdg    = own_heading_i;
    side_in.cog    = tgt_course_i;
    side_in.sog    = tgt_speed_kn_i;
    side_in.own_kn = kn_prod[32:16];
    side_in.zero   = (own_east_i == tgt_east_i) && (own_north_i == tgt_north_i);
  end

  always_ff @(posedge clk_i) begin
    de_q      <= diff_t'(tgt_east_i) - diff_t'(own_east_i);
    dn_q      <= diff_t'(tgt_north_i) - diff_t'(own_north_i);
    side_q[0] <= side_in;
    for (int k = 1; k <= T_MUL; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= T_MUL; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else begin
      valid_q[0] <= accept;
      for (int k = 1; k <= T_MUL; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // range: squares, sum, root
  logic [32:0] ae;
  logic [32:0] an;
  logic [65:0] sq_e_q;
  logic [65:0] sq_n_q;
  logic [65:0] sq_sum;
  logic [63:0] rad_q;
  logic        sqrt_vld;
  logic [31:0] root;
  logic [31:0] rng_q [RNG_N];

  assign ae     = (de_q < 0) ? 33'(-de_q) : 33'(de_q);
  assign an     = (dn_q < 0) ? 33'(-dn_q) : 33'(dn_q);
  assign sq_sum = sq_e_q + sq_n_q;

  always_ff @(posedge clk_i) begin
    sq_e_q <= 66'(ae) * 66'(ae);
    sq_n_q <= 66'(an) * 66'(an);
    rad_q  <= (sq_sum[65:64] != 2'b00) ? '1 : sq_sum[63:0];
  end

  crbr_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_q[2]),
    .rad_i   (rad_q),
    .valid_o (sqrt_vld),
    .root_o  (root)
  );

  always_ff @(posedge clk_i) begin
    rng_q[0] <= root;
    for (int k = 1; k < RNG_N; k++) begin
      rng_q[k] <= rng_q[k-1];
    end
  end

  // bearing
  logic        vec_vld;
  logic [31:0] theta;
  logic [31:0] ang_t_q;
  logic [31:0] ang_o_q;
  logic [31:0] tb_round;
  logic [15:0] tb_q [TB_N];

  crbr_vec u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_q[0]),
    .e_i     (de_q),
    .n_i     (dn_q),
    .valid_o (vec_vld),
    .theta_o (theta)
  );

  assign tb_round = theta + 32'd32768;

  always_ff @(posedge clk_i) begin
    ang_t_q  <= {side_q[T_THETA].cog, 16'h0000} - theta;
    ang_o_q  <= {side_q[T_THETA].hdg, 16'h0000} - theta;
    tb_q[0]  <= tb_round[31:16];
    for (int k = 1; k < TB_N; k++) begin
      tb_q[k] <= tb_q[k-1];
    end
  end

  // cosines and range rate
  logic               rot_t_vld;
  logic               rot_o_vld;
  logic signed [31:0] cos_t;
  logic signed [31:0] cos_o;
  logic signed [16:0] sog_s;
  logic signed [17:0] kn_s;
  logic signed [51:0] p_t_q;
  logic signed [51:0] p_o_q;
  logic signed [51:0] r_diff;
  logic signed [51:0] r_shift;
  logic signed [21:0] r_rnd;
  logic signed [18:0] radial;

  crbr_rot u_rot_tgt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_q[T_ANG]),
    .ang_i   (ang_t_q),
    .valid_o (rot_t_vld),
    .cos_o   (cos_t)
  );

  crbr_rot u_rot_own (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_q[T_ANG]),
    .ang_i   (ang_o_q),
    .valid_o (rot_o_vld),
    .cos_o   (cos_o)
  );

  assign sog_s = signed'({1'b0, side_q[T_COS].sog});
  assign kn_s  = signed'({1'b0, side_q[T_COS].own_kn});

  always_ff @(posedge clk_i) begin
    p_t_q <= 52'(sog_s) * 52'(cos_t);
    p_o_q <= 52'(kn_s) * 52'(cos_o);
  end

  always_comb begin
    r_diff  = p_t_q - p_o_q;
    r_shift = (r_diff + ROUND_HALF) >>> 30;
    r_rnd   = 22'(r_shift);
    if (r_rnd > RAD_MAX) begin
      radial = 19'(RAD_MAX);
    end else if (r_rnd < RAD_MIN) begin
      radial = 19'(RAD_MIN);
    end else begin
      radial = 19'(r_rnd);
    end
  end

  // result registers
  logic               done_q;
  logic [31:0]        range_q;
  logic [15:0]        tb_out_q;
  logic [15:0]        rel_q;
  logic signed [18:0] radial_q;
  logic               in_range_q;
  logic [15:0]        tb_fin;

  assign tb_fin = side_q[T_MUL].zero ? 16'h0000 : tb_q[TB_N-1];

  always_ff @(posedge clk_i) begin
    range_q    <= rng_q[RNG_N-1];
    tb_out_q   <= tb_fin;
    rel_q      <= tb_fin - side_q[T_MUL].hdg;
    radial_q   <= side_q[T_MUL].zero ? '0 : radial;
    in_range_q <= rng_q[RNG_N-1] <= max_range_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q[T_MUL];
    end
  end

  assign done_o         = done_q;
  assign target_range_o = range_q;
  assign true_bearing_o = tb_out_q;
  assign rel_bearing_o  = signed'(rel_q);
  assign radial_speed_o = radial_q;
  assign is_closing_o   = radial_q[18];
  assign in_range_o     = in_range_q;

  `CRBR_ASSERT_IMP(a_done_from_req, clk_i, rst_ni, done_o, $past(accept, T_OUT + 1))
  `CRBR_ASSERT_NEXT(a_tail_to_done, clk_i, rst_ni, valid_q[T_MUL], done_o)
  `CRBR_ASSERT_IMP(a_zero_range, clk_i, rst_ni, done_o && (target_range_o == 32'd0), (radial_speed_o == 19'sd0) && (true_bearing_o == 16'd0))
  `CRBR_ASSERT_IMP(a_cos_align, clk_i, rst_ni, 1'b1, (rot_t_vld == rot_o_vld) && (rot_t_vld == valid_q[T_COS]))
  `CRBR_ASSERT_IMP(a_unit_align, clk_i, rst_ni, 1'b1, (vec_vld == valid_q[T_THETA]) && (sqrt_vld == valid_q[T_RNG]))

endmodule

### tb/sv/contact_range_bearing_rate_test.sv
`timescale 1ns / 100ps

module contact_range_bearing_rate_test;
  import crbr_pkg::*;

  localparam logic [2:0] MAX_RANGE_ADDR = 3'(4 * REG_MAX_RANGE);
  localparam logic [2:0] UNMAPPED_ADDR  = 3'd4;
  localparam int         DRAIN_CYCLES   = 80;
  localparam int         PHASE_ITEMS    = 385;

  typedef struct {
    logic signed [31:0] own_e;
    logic signed [31:0] own_n;
    logic [15:0]        hdg;
    logic [15:0]        own_spd;
    logic signed [31:0] tgt_e;
    logic signed [31:0] tgt_n;
    logic [15:0]        cog;
    logic [15:0]        sog;
  } contact_t;

  typedef struct {
    logic [31:0]        range_v;
    logic [15:0]        tb;
    logic [15:0]        rb;
    logic [18:0]        radial;
    logic               closing;
    logic               inr;
  } track_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic start, busy, done_o;
  contact_t req;
  logic [31:0]        target_range_o;
  logic [15:0]        true_bearing_o;
  logic signed [15:0] rel_bearing_o;
  logic signed [18:0] radial_speed_o;
  logic               is_closing_o, in_range_o;
  int errors = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  class track_board;
    logic [31:0] max_range = MAX_RANGE_RST;
    track_t      tracks[$];
    longint      atan_q30[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                                  21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                                  333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                                  1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

    function logic [31:0] root(input longint unsigned s);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= res + b) begin
          s -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res[31:0];
    endfunction

    function logic [31:0] bearing_angle(input longint e, input longint n);
      longint x, y, z, xs, ys;
      x = n; y = e; z = 0;
      if (x < 0) begin
        x = -x; y = -y; z = 64'sd2147483648;
      end
      for (int i = 0; i < 30; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += atan_q30[i];
        end else begin
          x -= ys; y += xs; z -= atan_q30[i];
        end
      end
      return z[31:0];
    endfunction

    function longint cosine(input logic [31:0] a);
      longint s, x, y, xs, ys;
      bit neg;
      s = longint'($signed(a));
      x = 652032874; y = 0; neg = 0;
      if (s > 1073741824) begin
        s -= 64'sd2147483648; neg = 1;
      end else if (s < -1073741824) begin
        s += 64'sd2147483648; neg = 1;
      end
      for (int i = 0; i < 30; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (s >= 0) begin
          x -= ys; y += xs; s -= atan_q30[i];
        end else begin
          x += ys; y -= xs; s += atan_q30[i];
        end
      end
      return neg ? -x : x;
    endfunction

    function void note(input contact_t c);
      longint de, dn, own_kn, r, rad;
      longint unsigned ae, an, sq_e, sum;
      logic [31:0] theta, rounded;
      track_t t;
      de = longint'(c.tgt_e) - longint'(c.own_e);
      dn = longint'(c.tgt_n) - longint'(c.own_n);
      ae = de < 0 ? -de : de;
      an = dn < 0 ? -dn : dn;
      sq_e = ae * ae;
      sum = sq_e + an * an;
      t.range_v = (sum < sq_e) ? 32'hFFFF_FFFF : root(sum);
      t.tb = '0;
      rad = 0;
      if (de != 0 || dn != 0) begin
        theta = bearing_angle(de, dn);
        own_kn = (longint'(c.own_spd) * 127392 + 32768) >>> 16;
        r = longint'(c.sog) * cosine({c.cog, 16'd0} - theta)
          - own_kn * cosine({c.hdg, 16'd0} - theta);
        rounded = theta + 32'd32768;
        t.tb = rounded[31:16];
        rad = (r + (64'sd1 << 29)) >>> 30;
        if (rad > 262143) rad = 262143;
        if (rad < -262144) rad = -262144;
      end
      t.rb = t.tb - c.hdg;
      t.radial = rad[18:0];
      t.closing = rad < 0;
      t.inr = t.range_v <= max_range;
      tracks.push_back(t);
    endfunction

    task check(input track_t got);
      track_t w;
      if (tracks.size() == 0) begin
        report("unexpected result", got.range_v, 0);
        return;
      end
      w = tracks.pop_front();
      if (got.range_v !== w.range_v) report("target_range", got.range_v, w.range_v);
      if (got.tb !== w.tb) report("true_bearing", got.tb, w.tb);
      if (got.rb !== w.rb) report("rel_bearing", got.rb, w.rb);
      if (got.radial !== w.radial) report("radial_speed", got.radial, w.radial);
      if (got.closing !== w.closing) report("is_closing", got.closing, w.closing);
      if (got.inr !== w.inr) report("in_range", got.inr, w.inr);
    endtask
  endclass

  track_board board = new();

  contact_range_bearing_rate i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy,
    .own_east_i(req.own_e), .own_north_i(req.own_n), .own_heading_i(req.hdg),
    .own_speed_i(req.own_spd), .tgt_east_i(req.tgt_e), .tgt_north_i(req.tgt_n),
    .tgt_course_i(req.cog), .tgt_speed_kn_i(req.sog),
    .done_o, .target_range_o, .true_bearing_o, .rel_bearing_o, .radial_speed_o,
    .is_closing_o, .in_range_o
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    track_t got;
    if (rst_ni) begin
      if (start && !busy) board.note(req);
      if (done_o) begin
        got.range_v = target_range_o;
        got.tb = true_bearing_o;
        got.rb = rel_bearing_o;
        got.radial = radial_speed_o;
        got.closing = is_closing_o;
        got.inr = in_range_o;
        board.check(got);
      end
    end
  end

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    logic rdy;
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == MAX_RANGE_ADDR) board.max_range = data;
  endtask

  task automatic send(input contact_t c);
    logic b;
    start <= 1;
    req <= c;
    do begin
      @(negedge clk_i);
      b = busy;
      @(posedge clk_i);
    end while (b);
  endtask

  task automatic pause(input bit gaps);
    if (gaps && $urandom_range(99) < 18) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (board.tracks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic contact_t random_contact();
    contact_t c;
    int kind;
    c.hdg = $urandom(); c.own_spd = $urandom(); c.cog = $urandom(); c.sog = $urandom();
    c.own_e = $urandom(); c.own_n = $urandom();
    c.tgt_e = $urandom(); c.tgt_n = $urandom();
    kind = $urandom_range(9);
    if (kind >= 1 && kind <= 7) begin
      c.own_e = $signed(c.own_e) >>> 1;
      c.own_n = $signed(c.own_n) >>> 1;
      c.tgt_e = c.own_e + $signed(32'($urandom_range(800000)) - 32'sd400000);
      c.tgt_n = c.own_n + $signed(32'($urandom_range(800000)) - 32'sd400000);
    end else if (kind == 8) begin
      c.tgt_e = c.own_e;
      c.tgt_n = c.own_n;
    end else if (kind == 9) begin
      c.own_e = $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      c.own_n = $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      c.tgt_e = ~c.own_e;
      c.tgt_n = $urandom_range(1) ? ~c.own_n : c.own_n;
    end
    return c;
  endfunction

  function automatic contact_t mk(input int oe, on, input int te, tn,
                                  input logic [15:0] h, s, cg, sg);
    contact_t c;
    c.own_e = oe; c.own_n = on; c.hdg = h; c.own_spd = s;
    c.tgt_e = te; c.tgt_n = tn; c.cog = cg; c.sog = sg;
    return c;
  endfunction

  initial begin
    contact_t directed[$];
    logic [31:0] ranges[$];
    rst_ni = 0; start = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    req = mk(0, 0, 0, 0, 0, 0, 0, 0);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    directed = '{
      mk(0, 0, 0, 0, 16'h1234, 16'hFFFF, 16'h4000, 16'hFFFF),
      mk(100, -100, 100, -100, 0, 0, 0, 0),
      mk(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 100, 0, 100),
      mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      mk(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF),
      mk(0, 0, 0, -5000, 0, 16'hFFFF, 16'h8000, 16'hFFFF),
      mk(0, 0, 0, -1, 16'h4000, 256, 16'h0000, 256),
      mk(0, 0, 7000, 0, 16'h4000, 1000, 16'hC000, 2000),
      mk(0, 0, -7000, 0, 16'hC000, 1000, 16'h4000, 2000),
      mk(0, 0, 3000, 3000, 16'h2000, 16'hFFFF, 16'hA000, 0),
      mk(-50, 20, -50 + 355584, 20, 0, 512, 16'h4000, 512),
      mk(-50, 20, -50 + 355585, 20, 0, 512, 16'hC000, 512),
      mk(0, 0, 1, 1, 16'h7FFF, 0, 16'h8001, 16'hFFFF),
      mk(10, 10, 10, 11, 16'h8000, 16'hFFFF, 16'h0000, 0),
      mk(0, 0, -3, 2, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF)
    };
    foreach (directed[i]) send(directed[i]);

    ranges = '{MAX_RANGE_RST, 32'd0, 32'hFFFF_FFFF, $urandom(), 32'd160000};
    foreach (ranges[p]) begin
      if (p != 0) begin
        drain();
        cfg_write(MAX_RANGE_ADDR, ranges[p]);
        if (p == 3) cfg_write(UNMAPPED_ADDR, $urandom());
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send(random_contact());
        pause(!(p == 1 && k < 150));
      end
    end
    drain();
    if (errors == 0) $display("contact_range_bearing_rate_test passed");
    else $display("contact_range_bearing_rate_test failed");
    $finish;
  end

  initial begin
    #3ms;
    $display("contact_range_bearing_rate_test failed");
    $finish;
  end
endmodule
